>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/feg_pkg.sv
// types, codes and the rate increment table of the filter envelope generator
`timescale 1ns / 1ps

package feg_pkg;

  localparam int LEVEL_W = 13;
  localparam int CNT_W   = 14;
  localparam int BASE_W  = 5;
  localparam int RATE_W  = 6;
  localparam int INC_W   = 4;
  localparam int CFG_W   = 52;
  localparam int IDX_W   = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 13'h1FFF;

  // item modes
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_KEY_ON  = 2'd1;
  localparam logic [1:0] MODE_KEY_OFF = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_START_LEVEL = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGETS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_RATES       = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY_SCALE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OCTAVE      = 3'd4;
  localparam logic [IDX_W-1:0] REG_FNUM_BIT9   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SLOW_OFFSET = 3'd6;
  localparam logic [IDX_W-1:0] REG_STEP_KOFF   = 3'd7;

  localparam logic [3:0] KEY_SCALE_OFF = 4'd15;

  // rate thresholds
  localparam logic [RATE_W-1:0] RATE_FAST = 6'd48;
  localparam logic [RATE_W-1:0] RATE_TOP  = 6'd60;
  localparam logic [RATE_W-1:0] RATE_MAX  = 6'd63;
  localparam logic [3:0]        SHIFT_MAX = 4'd11;
  localparam logic [4:0]        ROW_TOP   = 5'd16;
  localparam logic [4:0]        ROW_FAST_OFS = 5'd12;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY1  = 2'd1,
    PH_DECAY2  = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         start_level;
    logic [3:0][LEVEL_W-1:0]    target;
    logic [3:0][BASE_W-1:0]     rate;
    logic [3:0]                 key_scale;
    logic signed [3:0]          octave;
    logic                       fnum_bit9;
    logic                       slow_offset;
    logic                       step_on_key_off;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_t             phase;
    logic               falling;
    logic               passed;
  } env_state_t;

  localparam logic [INC_W-1:0] INC_TABLE [17][8] = '{
    '{4'd0,4'd1,4'd0,4'd1,4'd0,4'd1,4'd0,4'd1},
    '{4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd0,4'd1},
    '{4'd0,4'd1,4'd1,4'd1,4'd0,4'd1,4'd1,4'd1},
    '{4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd2,4'd1,4'd2,4'd1,4'd2},
    '{4'd1,4'd2,4'd2,4'd2,4'd1,4'd2,4'd2,4'd2},
    '{4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2},
    '{4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd2,4'd2},
    '{4'd2,4'd4,4'd2,4'd4,4'd2,4'd4,4'd2,4'd4},
    '{4'd2,4'd4,4'd4,4'd4,4'd2,4'd4,4'd4,4'd4},
    '{4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4},
    '{4'd4,4'd8,4'd4,4'd4,4'd4,4'd8,4'd4,4'd4},
    '{4'd4,4'd8,4'd4,4'd8,4'd4,4'd8,4'd4,4'd8},
    '{4'd4,4'd8,4'd8,4'd8,4'd4,4'd8,4'd8,4'd8},
    '{4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8}
  };

  function automatic logic [INC_W-1:0] inc_lookup(input logic [4:0] row,
                                                  input logic [2:0] col);
    logic [INC_W-1:0] val;
    val = '0;
    if (row <= ROW_TOP) begin
      val = INC_TABLE[row][col];
    end
    return val;
  endfunction

endpackage

>>> src/feg_in_if.sv
// input item channel: mode, envelope clock strobe and envelope counter
`timescale 1ns / 1ps

interface feg_in_if;
  import feg_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic              clock_tick;
  logic [CNT_W-1:0]  env_count;

  modport source (output valid, output mode, output clock_tick, output env_count,
                  input ready);
  modport sink   (input valid, input mode, input clock_tick, input env_count,
                  output ready);
endinterface

>>> src/feg_out_if.sv
// result item channel: envelope level and phase
`timescale 1ns / 1ps

interface feg_out_if;
  import feg_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  level;
  logic [1:0]          phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

>>> src/filter_envelope_generator_unit.sv
// top level of the filter envelope generator
`timescale 1ns / 1ps

// filter envelope generator: one input item per audio sample, one result item
// (level and phase) per input item, in order. an accepted item waits in an
// input register until the result register is free or being drained; then the
// next envelope state is worked out in one pass (key event, phase advance, rate
// lookup, saturating step) and written to the state and result registers at the
// same edge. sustained rate is one item per cycle while the output is not
// stalled; the loop through the level and phase registers is what sets it.
// while a finished result waits the input still takes one item into an empty
// input register; it stalls only when both stages are full. there is no
// clearing pass after reset. configuration is written through the cfg_ port,
// one register per write, and should only change while no item is in flight.
module filter_envelope_generator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  feg_in_if.sink                      in_ch,
  feg_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [feg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [feg_pkg::CFG_W-1:0]   cfg_wdata
);
  import feg_pkg::*;

  cfg_t                cfg;

  // input stage
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [1:0]          s1_mode_r;
  logic                s1_tick_r;
  logic [CNT_W-1:0]    s1_cnt_r;
  logic                s1_adv;
  logic                in_take;

  // envelope state and result register
  env_state_t          st_r;
  env_state_t          st_nxt;
  env_state_t          step_res;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [1:0]          out_phase_r;

  feg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  feg_step u_step (
    .cfg        (cfg),
    .cur        (st_r),
    .mode       (s1_mode_r),
    .clock_tick (s1_tick_r),
    .env_count  (s1_cnt_r),
    .nxt        (step_res)
  );

  // input stage moves on when the result register is free or being drained
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    st_nxt        = s1_adv ? step_res : st_r;
  end

  // control and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_ch.mode;
      s1_tick_r <= in_ch.clock_tick;
      s1_cnt_r  <= in_ch.env_count;
    end
    if (s1_adv) begin
      out_level_r <= step_res.level;
      out_phase_r <= step_res.phase;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;
  assign out_ch.phase = out_phase_r;

endmodule

>>> src/feg_cfg.sv
// configuration register file with index decode
`timescale 1ns / 1ps

module feg_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [feg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [feg_pkg::CFG_W-1:0]   cfg_wdata,
  output feg_pkg::cfg_t               cfg
);
  import feg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  cfg_t cfg_rst;

  // reset values: all zero but key scaling, which starts off
  always_comb begin
    cfg_rst           = '0;
    cfg_rst.key_scale = KEY_SCALE_OFF;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_LEVEL: cfg_nxt.start_level     = cfg_wdata[LEVEL_W-1:0];
        REG_TARGETS:     cfg_nxt.target          = cfg_wdata[4*LEVEL_W-1:0];
        REG_RATES:       cfg_nxt.rate            = cfg_wdata[4*BASE_W-1:0];
        REG_KEY_SCALE:   cfg_nxt.key_scale       = cfg_wdata[3:0];
        REG_OCTAVE:      cfg_nxt.octave          = signed'(cfg_wdata[3:0]);
        REG_FNUM_BIT9:   cfg_nxt.fnum_bit9       = cfg_wdata[0];
        REG_SLOW_OFFSET: cfg_nxt.slow_offset     = cfg_wdata[0];
        REG_STEP_KOFF:   cfg_nxt.step_on_key_off = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/feg_rate.sv
// key-scaled effective rate and rate table increment for one phase
`timescale 1ns / 1ps

module feg_rate (
  input  feg_pkg::cfg_t                cfg,
  input  logic [feg_pkg::BASE_W-1:0]   base,
  input  logic [feg_pkg::CNT_W-1:0]    env_count,
  output logic [feg_pkg::INC_W-1:0]    inc
);
  import feg_pkg::*;

  logic signed [5:0]   key_sum;
  logic [3:0]          key_clip;
  logic [4:0]          scale_add;
  logic [6:0]          rate_raw;
  logic [RATE_W-1:0]   rate;
  logic [3:0]          shift;
  logic [CNT_W-1:0]    cnt_adj;
  logic [CNT_W-1:0]    cnt_low;
  logic [CNT_W-1:0]    cnt_shr;
  logic [4:0]          row;
  logic [2:0]          col;

  // key scaling
  always_comb begin
    key_sum   = signed'({2'b00, cfg.key_scale}) + 6'(cfg.octave);
    key_clip  = (key_sum > 6'sd15) ? 4'd15 : key_sum[3:0];
    scale_add = '0;
    if (cfg.key_scale != KEY_SCALE_OFF && !key_sum[5]) begin
      scale_add = {key_clip, cfg.fnum_bit9};
    end
    rate_raw = {1'b0, base, 1'b0} + 7'(scale_add);
    if (base == '0) begin
      rate = '0;
    end else if (rate_raw > 7'(RATE_MAX)) begin
      rate = RATE_MAX;
    end else begin
      rate = rate_raw[RATE_W-1:0];
    end
  end

  // table row and column, slow rates gate on the low counter bits
  always_comb begin
    shift   = SHIFT_MAX - rate[5:2];
    cnt_adj = cfg.slow_offset ? (env_count - 14'd1) : env_count;
    cnt_low = cnt_adj & ~({CNT_W{1'b1}} << shift);
    cnt_shr = cnt_adj >> shift;
    row     = '0;
    col     = '0;
    inc     = '0;
    if (rate == '0) begin
      inc = '0;
    end else if (rate < RATE_FAST) begin
      row = {3'b000, rate[1:0]};
      col = cnt_shr[2:0];
      inc = (cnt_low != '0) ? '0 : inc_lookup(row, col);
    end else begin
      // dropping bit 5 maps rates 48..59 onto rows 4..15
      row = (rate >= RATE_TOP) ? ROW_TOP : (5'(rate) - ROW_FAST_OFS);
      col = env_count[2:0];
      inc = inc_lookup(row, col);
    end
  end

endmodule

>>> src/feg_step.sv
// next envelope state for one item: key events, phase advance and level step
`timescale 1ns / 1ps

module feg_step (
  input  feg_pkg::cfg_t               cfg,
  input  feg_pkg::env_state_t         cur,
  input  logic [1:0]                  mode,
  input  logic                        clock_tick,
  input  logic [feg_pkg::CNT_W-1:0]   env_count,
  output feg_pkg::env_state_t         nxt
);
  import feg_pkg::*;

  logic [LEVEL_W-1:0]  lvl_a;
  phase_t              ph_a;
  logic                fall_a;
  logic                pas_a;
  logic                do_step;
  phase_t              ph_b;
  logic                fall_b;
  logic                pas_b;
  logic [INC_W-1:0]    inc;
  logic [LEVEL_W-1:0]  tgt;
  logic [LEVEL_W:0]    up_sum;
  logic [LEVEL_W-1:0]  nv;
  logic                above;
  logic                nabove;

  // key events and advance past a crossed target
  always_comb begin
    lvl_a   = cur.level;
    ph_a    = cur.phase;
    fall_a  = cur.falling;
    pas_a   = cur.passed;
    do_step = clock_tick;
    case (mode)
      MODE_KEY_ON: begin
        lvl_a   = cfg.start_level;
        ph_a    = PH_ATTACK;
        fall_a  = cfg.start_level >= cfg.target[PH_ATTACK];
        pas_a   = 1'b0;
        do_step = 1'b0;
      end
      MODE_KEY_OFF: begin
        ph_a    = PH_RELEASE;
        fall_a  = cur.level >= cfg.target[PH_RELEASE];
        pas_a   = 1'b0;
        do_step = clock_tick && cfg.step_on_key_off;
      end
      default: ;
    endcase

    ph_b   = ph_a;
    fall_b = fall_a;
    pas_b  = pas_a;
    if (do_step && pas_a && (ph_a inside {PH_ATTACK, PH_DECAY1})) begin
      ph_b   = phase_t'(ph_a + 2'd1);
      fall_b = lvl_a >= cfg.target[ph_b];
      pas_b  = 1'b0;
    end
  end

  feg_rate u_rate (
    .cfg       (cfg),
    .base      (cfg.rate[ph_b]),
    .env_count (env_count),
    .inc       (inc)
  );

  // saturating step toward the target
  always_comb begin
    tgt    = cfg.target[ph_b];
    up_sum = {1'b0, lvl_a} + 14'(inc);
    if (fall_b) begin
      nv = (lvl_a < 13'(inc)) ? '0 : (lvl_a - 13'(inc));
    end else begin
      nv = up_sum[LEVEL_W] ? LEVEL_MAX : up_sum[LEVEL_W-1:0];
    end
    above  = lvl_a >= tgt;
    nabove = nv >= tgt;

    nxt.level   = lvl_a;
    nxt.phase   = ph_b;
    nxt.falling = fall_b;
    nxt.passed  = pas_b;
    if (do_step && (inc != '0) && !pas_b) begin
      if (ph_b inside {PH_DECAY2, PH_RELEASE}) begin
        // hold phases stop short of the target
        if (nabove == above) begin
          nxt.level = nv;
        end
      end else begin
        nxt.level = nv;
        if (nabove != above) begin
          nxt.passed = 1'b1;
        end
      end
    end
  end

endmodule

>>> src/feg_checker.sv
// port-level checks for the filter envelope generator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module feg_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [feg_pkg::LEVEL_W-1:0]   out_level,
  input  logic [1:0]                    out_phase
);
  import feg_pkg::*;

  logic                 out_stall;
  logic [LEVEL_W+1:0]   out_pay;

  assign out_stall = out_valid && !out_ready;
  assign out_pay   = {out_level, out_phase};

  // result register is empty after reset
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input only stalls when both stages are full
  `ASSERT_CLK(a_stall_cause, !in_ready |-> out_stall, "input stall without full output")

  // an accepted item leads to a valid result once it has passed the input and result registers
  `ASSERT_CLK(a_accept_result, (in_valid && in_ready) |=> ##1 out_valid, "accepted item lost")

  // a waiting result keeps its payload
  `ASSERT_CLK(a_out_hold, out_stall |=> (out_valid && $stable(out_pay)), "stalled result moved")

endmodule

bind filter_envelope_generator_unit feg_checker u_feg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level),
  .out_phase (out_ch.phase)
);
